[rtl/core/pcpool_pkg.sv]
// Shared constants, codes and control types of the per-CPU page pool.
`timescale 1ns / 1ps

package pcpool_pkg;

   // Default sizing, handed to the top level as parameter defaults.
   localparam int NUM_CPUS_DEFAULT   = 8;
   localparam int NUM_PAGES_DEFAULT  = 32768;
   localparam int PAGE_BYTES_DEFAULT = 4096;

   // Field widths fixed by the channel definitions.
   localparam int ADDR_W   = 32;
   localparam int CPU_W    = 3;
   localparam int STATUS_W = 2;

   // Request actions.
   localparam logic ACTION_FREE  = 1'b0;
   localparam logic ACTION_ALLOC = 1'b1;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_MEM   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

   // Configuration register indexes.
   localparam logic CSR_LOW_LIMIT  = 1'b0;
   localparam logic CSR_HIGH_LIMIT = 1'b1;

   // Configuration register reset values.
   localparam logic [ADDR_W-1:0] LOW_LIMIT_RESET  = 32'h8000_0000;
   localparam logic [ADDR_W-1:0] HIGH_LIMIT_RESET = 32'h8800_0000;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch;   // capture the accepted request
      logic look;    // check the address, pick the source list, read its head
      logic fetch;   // read the next link of the head page
      logic push;    // link the freed page in and make it the head
      logic report;  // finish with no change to the lists
      logic pop;     // move the head along and deliver the page
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_alloc;
      logic bad;
      logic found;
      logic out_free;
   } dp_status_type;

endpackage

[rtl/core/pcpool_if.sv]
// Request and result channel interfaces of the per-CPU page pool.
`timescale 1ns / 1ps

interface pcpool_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [2:0]  cpu;
   logic [31:0] address;

   modport source (output valid, output action, output cpu, output address, input ready);
   modport sink   (input valid, input action, input cpu, input address, output ready);
endinterface

interface pcpool_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] page_address;
   logic        stolen;
   logic [2:0]  source_cpu;

   modport source (output valid, output status, output page_address, output stolen,
                   output source_cpu, input ready);
   modport sink   (input valid, input status, input page_address, input stolen,
                   input source_cpu, output ready);
endinterface

[rtl/core/pcpool_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module pcpool_ram #(
   parameter int Width = 16,
   parameter int Depth = 32768
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  logic [Width-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic [Width-1:0]                       rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/pcpool_dp.sv]
// Datapath of the per-CPU page pool: limits, list heads, link memory and result register.
`timescale 1ns / 1ps

module pcpool_dp import pcpool_pkg::*; #(
   parameter int NumCpus   = NUM_CPUS_DEFAULT,
   parameter int NumPages  = NUM_PAGES_DEFAULT,
   parameter int PageBytes = PAGE_BYTES_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  ctrl_cmd_type        cmd,
   output dp_status_type       stat,
   input  logic                req_action,
   input  logic [CPU_W-1:0]    req_cpu,
   input  logic [ADDR_W-1:0]   req_address,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [ADDR_W-1:0]   csr_wdata,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [ADDR_W-1:0]   rsp_page_address,
   output logic                rsp_stolen,
   output logic [CPU_W-1:0]    rsp_source_cpu
);

   localparam int CpuW      = (NumCpus > 1) ? $clog2(NumCpus) : 1;
   localparam int PageW     = $clog2(NumPages);
   localparam int PageShift = $clog2(PageBytes);
   localparam int HiW       = ADDR_W - PageShift;
   localparam logic [ADDR_W:0] PageMask = (ADDR_W+1)'(PageBytes - 1);
   localparam logic [ADDR_W:0] BaseReset =
      (ADDR_W+1)'(((64'(LOW_LIMIT_RESET) + 64'(PageBytes) - 64'd1) / 64'(PageBytes))
                  * 64'(PageBytes));

   // Configuration; the base is the low limit rounded up to a page.
   logic [ADDR_W-1:0] low_ff, low_in;
   logic [ADDR_W-1:0] high_ff, high_in;
   logic [ADDR_W:0]   base_ff, base_in;

   // Captured request and decisions.
   logic              act_ff;
   logic [CpuW-1:0]   cpu_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic              bad_ff;
   logic              found_ff;
   logic [CpuW-1:0]   src_ff;
   logic [PageW-1:0]  idx_ff;
   logic [PageW-1:0]  pg_ff;

   logic [NumCpus-1:0] head_vld_ff, head_vld_in;

   // Result register.
   logic                rsp_vld_ff, rsp_vld_in;
   logic [STATUS_W-1:0] status_ff;
   logic [ADDR_W-1:0]   page_ff;
   logic                stolen_ff;
   logic [CPU_W-1:0]    srccpu_ff;

   logic [6:0]        cpu_w;
   logic [CpuW-1:0]   cpu_red;
   logic [CpuW-1:0]   first_c;
   logic [CpuW-1:0]   src_c;
   logic [ADDR_W-1:0] offset;
   logic [HiW-1:0]    off_pages;
   logic              bad_c;
   logic [ADDR_W-1:0] alloc_addr;
   logic              load;
   logic              out_free;

   logic [CpuW-1:0]   head_raddr;
   logic [CpuW-1:0]   head_waddr;
   logic [PageW-1:0]  head_wdata;
   logic [PageW-1:0]  head_rd;
   logic [PageW:0]    link_rd;

   // Requested CPU reduced modulo the CPU count.
   always_comb begin
      cpu_w = {4'b0, req_cpu};
      for (int k = 0; k < 8; k++) begin
         if (cpu_w >= 7'(NumCpus)) begin
            cpu_w = cpu_w - 7'(NumCpus);
         end
      end
      cpu_red = CpuW'(cpu_w);
   end

   // Free address checks.
   always_comb begin
      offset    = addr_ff - base_ff[ADDR_W-1:0];
      off_pages = offset[ADDR_W-1:PageShift];
      bad_c     = (|addr_ff[PageShift-1:0])
                | (addr_ff < low_ff)
                | (addr_ff >= high_ff)
                | ({1'b0, addr_ff} < base_ff)
                | (ADDR_W'(off_pages) >= ADDR_W'(NumPages));
   end

   // Source list: own list if it holds a page, else the lowest non-empty one.
   always_comb begin
      first_c = '0;
      for (int i = NumCpus - 1; i >= 0; i--) begin
         if (head_vld_ff[i]) begin
            first_c = CpuW'(i);
         end
      end
      src_c = head_vld_ff[cpu_ff] ? cpu_ff : first_c;
   end

   assign head_raddr = (act_ff == ACTION_ALLOC) ? src_c : cpu_ff;
   assign head_waddr = cmd.push ? cpu_ff : src_ff;
   assign head_wdata = cmd.push ? idx_ff : link_rd[PageW-1:0];

   pcpool_ram #(
      .Width (PageW),
      .Depth (NumCpus)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (cmd.push | cmd.pop),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_en   (cmd.look),
      .rd_addr (head_raddr),
      .rd_data (head_rd)
   );

   // Each link carries a valid bit on top; an invalid link ends the list.
   pcpool_ram #(
      .Width (PageW + 1),
      .Depth (NumPages)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (idx_ff),
      .wr_data ({head_vld_ff[cpu_ff], head_rd}),
      .rd_en   (cmd.fetch),
      .rd_addr (head_rd),
      .rd_data (link_rd)
   );

   always_comb begin
      head_vld_in = head_vld_ff;
      if (cmd.push) begin
         head_vld_in[cpu_ff] = 1'b1;
      end
      if (cmd.pop) begin
         head_vld_in[src_ff] = link_rd[PageW];
      end
   end

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      base_in = base_ff;
      if (csr_we) begin
         if (csr_index == CSR_LOW_LIMIT) begin
            low_in  = csr_wdata;
            base_in = ({1'b0, csr_wdata} + PageMask) & ~PageMask;
         end else begin
            high_in = csr_wdata;
         end
      end
   end

   assign alloc_addr = base_ff[ADDR_W-1:0] + (ADDR_W'(pg_ff) << PageShift);
   assign out_free   = !rsp_vld_ff || rsp_ready;
   assign load       = cmd.push | cmd.report | cmd.pop;
   assign rsp_vld_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff      <= LOW_LIMIT_RESET;
         high_ff     <= HIGH_LIMIT_RESET;
         base_ff     <= BaseReset;
         head_vld_ff <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         low_ff      <= low_in;
         high_ff     <= high_in;
         base_ff     <= base_in;
         head_vld_ff <= head_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         act_ff  <= req_action;
         cpu_ff  <= cpu_red;
         addr_ff <= req_address;
      end
      if (cmd.look) begin
         bad_ff   <= bad_c;
         found_ff <= |head_vld_ff;
         src_ff   <= src_c;
         idx_ff   <= PageW'(off_pages);
      end
      if (cmd.fetch) begin
         pg_ff <= head_rd;
      end
      if (cmd.pop) begin
         status_ff <= STATUS_DONE;
         page_ff   <= alloc_addr;
         stolen_ff <= (src_ff != cpu_ff);
         srccpu_ff <= CPU_W'(src_ff);
      end else if (cmd.push || cmd.report) begin
         status_ff <= cmd.push ? STATUS_DONE
                    : ((act_ff == ACTION_ALLOC) ? STATUS_NO_MEM : STATUS_BAD_FREE);
         page_ff   <= '0;
         stolen_ff <= 1'b0;
         srccpu_ff <= '0;
      end
   end

   assign stat.is_alloc = (act_ff == ACTION_ALLOC);
   assign stat.bad      = bad_ff;
   assign stat.found    = found_ff;
   assign stat.out_free = out_free;

   assign rsp_valid        = rsp_vld_ff;
   assign rsp_status       = status_ff;
   assign rsp_page_address = page_ff;
   assign rsp_stolen       = stolen_ff;
   assign rsp_source_cpu   = srccpu_ff;

endmodule

[rtl/core/pcpool_ctrl.sv]
// Controller state machine of the per-CPU page pool.
`timescale 1ns / 1ps

module pcpool_ctrl import pcpool_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output ctrl_cmd_type  cmd,
   input  dp_status_type stat
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_LOOK  = 2'd1;
   localparam logic [1:0] S_APPLY = 2'd2;
   localparam logic [1:0] S_POP   = 2'd3;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.latch = 1'b1;
               state_in  = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.look = 1'b1;
            state_in = S_APPLY;
         end
         S_APPLY: begin
            if (stat.is_alloc && stat.found) begin
               cmd.fetch = 1'b1;
               state_in  = S_POP;
            end else if (stat.out_free) begin
               if (!stat.is_alloc && !stat.bad) begin
                  cmd.push = 1'b1;
               end else begin
                  cmd.report = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         S_POP: begin
            if (stat.out_free) begin
               cmd.pop  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/per_cpu_page_pool_with_steal.sv]
// Per-CPU page pool: a free request goes through look-up and update, an allocate through look-up,
// link read and pop. One request is in work at a time; its steps follow the registered reads of
// the list head memory and then of the link memory.
// The result register lets the next request be accepted while a result waits to be taken.
// Synchronous reset empties all lists and restores the limits; the link memory is not cleared.
`timescale 1ns / 1ps

module per_cpu_page_pool_with_steal import pcpool_pkg::*; #(
   parameter int NumCpus   = NUM_CPUS_DEFAULT,
   parameter int NumPages  = NUM_PAGES_DEFAULT,
   parameter int PageBytes = PAGE_BYTES_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   pcpool_req_if.sink        req_ch,
   pcpool_rsp_if.source      rsp_ch,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [ADDR_W-1:0] csr_wdata
);

   // The controller steps each request through capture, look-up, update and,
   // for an allocation, a second memory read to follow the link of the popped
   // page. The datapath holds the limits, the per-CPU list heads (valid bits in
   // flip-flops, page indexes in a small memory) and the link memory, in which
   // every page pushed records the previous head of its list.

   ctrl_cmd_type  cmd;
   dp_status_type stat;

   pcpool_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   // A freed address is checked against alignment, both limits and the size
   // of the pool before it is linked in; a bad one only reports its status.
   // An allocation that finds its own list empty takes the head of the lowest
   // numbered non-empty list and reports the page as stolen.
   pcpool_dp #(
      .NumCpus   (NumCpus),
      .NumPages  (NumPages),
      .PageBytes (PageBytes)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_ch.action),
      .req_cpu          (req_ch.cpu),
      .req_address      (req_ch.address),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_ready        (rsp_ch.ready),
      .rsp_valid        (rsp_ch.valid),
      .rsp_status       (rsp_ch.status),
      .rsp_page_address (rsp_ch.page_address),
      .rsp_stolen       (rsp_ch.stolen),
      .rsp_source_cpu   (rsp_ch.source_cpu)
   );

endmodule
